/* rtl/euler_zyx_rotation_matrix_macros.svh */
`ifndef EULER_ZYX_ROTATION_MATRIX_MACROS_SVH
`define EULER_ZYX_ROTATION_MATRIX_MACROS_SVH
`ifndef SYNTHESIS
`define EZR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error("lbl");
`define EZR_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error("lbl");
`else
`define EZR_ASSERT(lbl, prop)
`define EZR_NEVER(lbl, cond)
`endif
`endif

/* rtl/ezr_pkg.sv */
package ezr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ANG_W     = FRAC_BITS + 3;
    localparam int OUT_W     = FRAC_BITS + 2;
    localparam int WF        = 32;
    localparam int TF        = FRAC_BITS + 1;
    localparam int TV_W      = TF + 2;
    localparam int SUM_W     = TV_W + 1;
    localparam int CW        = WF + 4;
    localparam int N_ITER    = 32;
    localparam int IDX_W     = $clog2(N_ITER);
    localparam int N_AX      = 3;

    localparam logic signed [CW-1:0] GAIN   = CW'(64'h9B74EDA8);
    localparam logic signed [CW-1:0] T_ONE  = CW'(64'sd1 <<< TF);
    localparam logic signed [CW-1:0] T_HALF = CW'(64'sd1 <<< (WF - TF - 1));

    typedef logic signed [CW-1:0]   t_cw;
    typedef logic signed [TV_W-1:0] t_tv;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [OUT_W-1:0] t_out;

    typedef struct packed {
        t_cw x;
        t_cw y;
        t_cw z;
    } t_rot;

    typedef struct packed {
        logic                  vld;
        logic [N_AX-1:0][2:0]  q;
        t_rot [N_AX-1:0]       r;
    } t_cstage;

    typedef struct packed {
        logic vld;
        t_tv  sz;
        t_tv  cz;
        t_tv  sy;
        t_tv  cy;
        t_tv  sx;
        t_tv  cx;
    } t_trig;

    function automatic t_cw half_pi_mult(input logic [2:0] q);
        case (q)
            3'd0:    half_pi_mult = '0;
            3'd1:    half_pi_mult = CW'(64'h1921FB544);
            3'd2:    half_pi_mult = CW'(64'h3243F6A88);
            3'd3:    half_pi_mult = CW'(64'h4B65F1FCC);
            3'd4:    half_pi_mult = CW'(64'h6487ED510);
            3'd5:    half_pi_mult = CW'(64'h7DA9E8A54);
            default: half_pi_mult = '0;
        endcase
    endfunction

    function automatic logic [WF-1:0] atan_tab(input logic [IDX_W-1:0] i);
        case (i)
            5'd0:    atan_tab = 32'hC90FDAA2;
            5'd1:    atan_tab = 32'h76B19C16;
            5'd2:    atan_tab = 32'h3EB6EBF2;
            5'd3:    atan_tab = 32'h1FD5BA9B;
            5'd4:    atan_tab = 32'h0FFAADDC;
            5'd5:    atan_tab = 32'h07FF556F;
            5'd6:    atan_tab = 32'h03FFEAAB;
            5'd7:    atan_tab = 32'h01FFFD55;
            5'd8:    atan_tab = 32'h00FFFFAB;
            5'd9:    atan_tab = 32'h007FFFF5;
            5'd10:   atan_tab = 32'h003FFFFF;
            default: atan_tab = 32'h1 << (6'd32 - {1'b0, i});
        endcase
    endfunction

    function automatic t_tv mul_t(input t_tv a, input t_tv b);
        logic signed [2*TV_W-1:0] p;
        p = a * b;
        p = p + (2*TV_W)'(64'sd1 <<< (TF - 1));
        mul_t = p[TF +: TV_W];
    endfunction

    function automatic t_out finish(input t_sum v);
        logic signed [SUM_W-1:0] r;
        r = (v + SUM_W'(1)) >>> 1;
        if (r > SUM_W'(64'sd1 <<< FRAC_BITS)) begin
            r = SUM_W'(64'sd1 <<< FRAC_BITS);
        end else if (r < -SUM_W'(64'sd1 <<< FRAC_BITS)) begin
            r = -SUM_W'(64'sd1 <<< FRAC_BITS);
        end
        finish = r[OUT_W-1:0];
    endfunction

endpackage

/* rtl/ezr_cordic_cell.sv */
module ezr_cordic_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [ezr_pkg::IDX_W-1:0]    i_idx,
    input  ezr_pkg::t_cstage             i_st,
    output ezr_pkg::t_cstage             o_st
);
    import ezr_pkg::*;

    t_cstage r_st;
    t_cstage n_st;
    t_cw     w_t;

    assign w_t = CW'(atan_tab(i_idx));

    always_comb begin
        n_st     = i_st;
        for (int j = 0; j < N_AX; j++) begin
            if (!i_st.r[j].z[CW-1]) begin
                n_st.r[j].x = i_st.r[j].x - (i_st.r[j].y >>> i_idx);
                n_st.r[j].y = i_st.r[j].y + (i_st.r[j].x >>> i_idx);
                n_st.r[j].z = i_st.r[j].z - w_t;
            end else begin
                n_st.r[j].x = i_st.r[j].x + (i_st.r[j].y >>> i_idx);
                n_st.r[j].y = i_st.r[j].y - (i_st.r[j].x >>> i_idx);
                n_st.r[j].z = i_st.r[j].z + w_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.vld <= 1'b0;
        end else if (i_en) begin
            r_st.vld <= n_st.vld;
        end
        if (i_en) begin
            r_st.q <= n_st.q;
            r_st.r <= n_st.r;
        end
    end

    assign o_st = r_st;

endmodule

/* rtl/ezr_matrix.sv */
module ezr_matrix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  ezr_pkg::t_trig      i_trig,
    output logic                o_vld,
    output ezr_pkg::t_out [8:0] o_m
);
    import ezr_pkg::*;

    logic r_v1, r_v2, r_v3;
    t_tv  r_czsy, r_szsy, r_czcy, r_szcy, r_szcx, r_szsx, r_czcx, r_czsx, r_cysx, r_cycx;
    t_tv  r_sx, r_cx, r_sy;
    t_sum r_s01, r_s02, r_s11, r_s12, r_s00, r_s10, r_s20, r_s21, r_s22;
    t_out [8:0] r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_trig.vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_czsy <= mul_t(i_trig.cz, i_trig.sy);
            r_szsy <= mul_t(i_trig.sz, i_trig.sy);
            r_czcy <= mul_t(i_trig.cz, i_trig.cy);
            r_szcy <= mul_t(i_trig.sz, i_trig.cy);
            r_szcx <= mul_t(i_trig.sz, i_trig.cx);
            r_szsx <= mul_t(i_trig.sz, i_trig.sx);
            r_czcx <= mul_t(i_trig.cz, i_trig.cx);
            r_czsx <= mul_t(i_trig.cz, i_trig.sx);
            r_cysx <= mul_t(i_trig.cy, i_trig.sx);
            r_cycx <= mul_t(i_trig.cy, i_trig.cx);
            r_sx   <= i_trig.sx;
            r_cx   <= i_trig.cx;
            r_sy   <= i_trig.sy;

            r_s01 <= SUM_W'(mul_t(r_czsy, r_sx)) - SUM_W'(r_szcx);
            r_s02 <= SUM_W'(mul_t(r_czsy, r_cx)) + SUM_W'(r_szsx);
            r_s11 <= SUM_W'(mul_t(r_szsy, r_sx)) + SUM_W'(r_czcx);
            r_s12 <= SUM_W'(mul_t(r_szsy, r_cx)) - SUM_W'(r_czsx);
            r_s00 <= SUM_W'(r_czcy);
            r_s10 <= SUM_W'(r_szcy);
            r_s20 <= -SUM_W'(r_sy);
            r_s21 <= SUM_W'(r_cysx);
            r_s22 <= SUM_W'(r_cycx);

            r_m[0] <= finish(r_s00);
            r_m[1] <= finish(r_s01);
            r_m[2] <= finish(r_s02);
            r_m[3] <= finish(r_s10);
            r_m[4] <= finish(r_s11);
            r_m[5] <= finish(r_s12);
            r_m[6] <= finish(r_s20);
            r_m[7] <= finish(r_s21);
            r_m[8] <= finish(r_s22);
        end
    end

    assign o_vld = r_v3;
    assign o_m   = r_m;

endmodule

/* rtl/euler_zyx_rotation_matrix.sv */
// Z-Y-X Euler rotation matrix R = Rz * Ry * Rx, fully pipelined.
// Input channel (s_axis): one item carries angle_z, angle_y, angle_x, each
// unsigned Q3.16 radians. Output channel (m_axis): one item carries the nine
// elements m00..m22, signed Q1.16 saturated to [-1, 1].
// Every input item gives exactly one output item, in order.
// Stages from acceptance to o_m_axis_tvalid, in order:
// one quadrant-reduction stage, a row of 32 CORDIC cells (one rotation step
// each, all three angles side by side), one stage that rounds and maps the
// quadrant, and three stages of products, sums and saturation.
// Throughput: one item per cycle unless stalled; each CORDIC cell does one step.
// Stall: while an output item waits with i_m_axis_tready low, the whole
// pipeline holds and o_s_axis_tready is low; it resumes the cycle the item
// is taken. Bubbles in the pipeline are not squeezed out.
// Reset (i_rst_n low, synchronous) clears every stage valid bit; no item is
// in flight afterward. No state is kept between items.
module euler_zyx_rotation_matrix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // angle_z[18:0], angle_y[37:19], angle_x[56:38], zero [63:57]
    input  logic [63:0]   i_s_axis_tdata,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // m00[17:0], m01, m02, m10, m11, m12, m20, m21, m22[161:144], zero [167:162]
    output logic [167:0]  o_m_axis_tdata
);
    import ezr_pkg::*;
    `include "euler_zyx_rotation_matrix_macros.svh"

    logic    w_en;
    t_cstage r_st0;
    t_cstage n_st0;
    t_cstage w_st [0:N_ITER];
    t_trig   r_trig;
    t_trig   n_trig;
    t_tv     w_s [N_AX];
    t_tv     w_c [N_AX];
    logic    w_vld;
    t_out [8:0] w_m;

    assign w_en            = !w_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_comb begin
        logic [CW-1:0] a;
        logic [2:0]    q;
        n_st0     = '0;
        n_st0.vld = i_s_axis_tvalid;
        for (int j = 0; j < N_AX; j++) begin
            a = CW'({i_s_axis_tdata[j*ANG_W +: ANG_W], {(WF-FRAC_BITS){1'b0}}});
            q = '0;
            for (int k = 1; k <= 5; k++) begin
                if (a >= half_pi_mult(3'(k))) begin
                    q = 3'(k);
                end
            end
            n_st0.q[j]   = q;
            n_st0.r[j].x = GAIN;
            n_st0.r[j].y = '0;
            n_st0.r[j].z = t_cw'(a) - half_pi_mult(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st0.vld <= 1'b0;
        end else if (w_en) begin
            r_st0.vld <= n_st0.vld;
        end
        if (w_en) begin
            r_st0.q <= n_st0.q;
            r_st0.r <= n_st0.r;
        end
    end

    assign w_st[0] = r_st0;

    for (genvar g = 0; g < N_ITER; g++) begin : g_cell
        ezr_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_idx   (IDX_W'(g)),
            .i_st    (w_st[g]),
            .o_st    (w_st[g+1])
        );
    end

    always_comb begin
        t_cw rc;
        t_cw rs;
        t_tv c;
        t_tv s;
        for (int j = 0; j < N_AX; j++) begin
            rc = (w_st[N_ITER].r[j].x + T_HALF) >>> (WF - TF);
            rs = (w_st[N_ITER].r[j].y + T_HALF) >>> (WF - TF);
            if (rc > T_ONE) begin
                rc = T_ONE;
            end else if (rc < -T_ONE) begin
                rc = -T_ONE;
            end
            if (rs > T_ONE) begin
                rs = T_ONE;
            end else if (rs < -T_ONE) begin
                rs = -T_ONE;
            end
            c = rc[TV_W-1:0];
            s = rs[TV_W-1:0];
            case (w_st[N_ITER].q[j][1:0])
                2'd0: begin
                    w_c[j] = c;
                    w_s[j] = s;
                end
                2'd1: begin
                    w_c[j] = -s;
                    w_s[j] = c;
                end
                2'd2: begin
                    w_c[j] = -c;
                    w_s[j] = -s;
                end
                default: begin
                    w_c[j] = s;
                    w_s[j] = -c;
                end
            endcase
        end
        n_trig     = '0;
        n_trig.vld = w_st[N_ITER].vld;
        n_trig.sz  = w_s[0];
        n_trig.cz  = w_c[0];
        n_trig.sy  = w_s[1];
        n_trig.cy  = w_c[1];
        n_trig.sx  = w_s[2];
        n_trig.cx  = w_c[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig.vld <= 1'b0;
        end else if (w_en) begin
            r_trig.vld <= n_trig.vld;
        end
        if (w_en) begin
            r_trig.sz <= n_trig.sz;
            r_trig.cz <= n_trig.cz;
            r_trig.sy <= n_trig.sy;
            r_trig.cy <= n_trig.cy;
            r_trig.sx <= n_trig.sx;
            r_trig.cx <= n_trig.cx;
        end
    end

    ezr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_trig  (r_trig),
        .o_vld   (w_vld),
        .o_m     (w_m)
    );

    assign o_m_axis_tvalid = w_vld;
    assign o_m_axis_tdata  = {6'b0, w_m};

    `EZR_ASSERT(a_stall_blocks_input, (w_vld && !i_m_axis_tready) |-> !o_s_axis_tready)
    `EZR_NEVER(a_quadrant_range, r_st0.vld && (r_st0.q[0] > 3'd5 || r_st0.q[1] > 3'd5))
    `EZR_NEVER(a_trig_range, r_trig.vld && (r_trig.sy > t_tv'(T_ONE) || r_trig.sy < -t_tv'(T_ONE)))
    `EZR_ASSERT(a_stall_holds_trig, (w_vld && !i_m_axis_tready) |=> $stable(r_trig))

endmodule
